// File: rtl/mta_pkg.sv
package mta_pkg;

    localparam int ARG_W  = 32;
    localparam int DIFF_W = ARG_W + 1;
    localparam int NUM_W  = ARG_W + 2;
    localparam int ACC_W  = 2 * ARG_W + 2;
    localparam int QDEPTH = 2;

    localparam logic MODE_ORTHO     = 1'b0;
    localparam logic MODE_TRANSLATE = 1'b1;

    typedef struct packed {
        logic                     translate;
        logic                     load;
        logic                     bad;
        logic signed [ARG_W-1:0]  tx;
        logic signed [ARG_W-1:0]  ty;
        logic signed [ARG_W-1:0]  tz;
        logic signed [DIFF_W-1:0] rml;
        logic signed [DIFF_W-1:0] rpl;
        logic signed [DIFF_W-1:0] tmb;
        logic signed [DIFF_W-1:0] tpb;
        logic signed [DIFF_W-1:0] fmn;
        logic signed [DIFF_W-1:0] fpn;
    } t_cmd;

    function automatic logic signed [ARG_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(64'sd2147483647);
        lo = -ACC_W'(64'sd2147483648);
        if (v > hi) begin
            return 32'sh7fffffff;
        end else if (v < lo) begin
            return 32'sh80000000;
        end
        return v[ARG_W-1:0];
    endfunction

endpackage

// File: rtl/mta_front.sv
module mta_front (
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_mode,
    input  logic                          i_load,
    input  logic signed [31:0]            i_arg_a,
    input  logic signed [31:0]            i_arg_b,
    input  logic signed [31:0]            i_arg_c,
    input  logic signed [31:0]            i_arg_d,
    input  logic signed [31:0]            i_arg_e,
    input  logic signed [31:0]            i_arg_f,
    input  logic                          i_q_full,
    output logic                          o_push,
    output mta_pkg::t_cmd                 o_cmd
);

    logic signed [mta_pkg::DIFF_W-1:0] w_a, w_b, w_c, w_d, w_e, w_f;

    assign w_a = mta_pkg::DIFF_W'(i_arg_a);
    assign w_b = mta_pkg::DIFF_W'(i_arg_b);
    assign w_c = mta_pkg::DIFF_W'(i_arg_c);
    assign w_d = mta_pkg::DIFF_W'(i_arg_d);
    assign w_e = mta_pkg::DIFF_W'(i_arg_e);
    assign w_f = mta_pkg::DIFF_W'(i_arg_f);

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        o_cmd.translate = (i_mode == mta_pkg::MODE_TRANSLATE);
        o_cmd.load      = i_load;
        o_cmd.bad       = (i_mode == mta_pkg::MODE_ORTHO) &&
                          ((i_arg_a == i_arg_b) || (i_arg_d == i_arg_c) ||
                           (i_arg_e == i_arg_f));
        o_cmd.tx  = i_arg_a;
        o_cmd.ty  = i_arg_b;
        o_cmd.tz  = i_arg_c;
        o_cmd.rml = w_b - w_a;
        o_cmd.rpl = w_b + w_a;
        o_cmd.tmb = w_d - w_c;
        o_cmd.tpb = w_d + w_c;
        o_cmd.fmn = w_f - w_e;
        o_cmd.fpn = w_f + w_e;
    end

endmodule

// File: rtl/mta_fifo.sv
module mta_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mta_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output mta_pkg::t_cmd o_cmd
);

    localparam int PW = (mta_pkg::QDEPTH > 1) ? $clog2(mta_pkg::QDEPTH) : 1;
    localparam int CW = $clog2(mta_pkg::QDEPTH + 1);

    mta_pkg::t_cmd r_mem [mta_pkg::QDEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(mta_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(mta_pkg::QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(mta_pkg::QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: rtl/mta_div.sv
module mta_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [mta_pkg::NUM_W-1:0]    i_num,
    input  logic signed [mta_pkg::DIFF_W-1:0]   i_den,
    output logic                                o_done,
    output logic signed [mta_pkg::ARG_W-1:0]    o_quot
);

    localparam int MW = mta_pkg::DIFF_W;
    localparam int DW = MW + FRAC_BITS;
    localparam int CW = $clog2(DW);

    logic [DW-1:0]  r_dvd;
    logic [MW-1:0]  r_rem;
    logic [MW-1:0]  r_den;
    logic           r_neg;
    logic           r_busy;
    logic           r_done;
    logic [CW-1:0]  r_cnt;

    logic [mta_pkg::NUM_W-1:0] w_nabs;
    logic [MW-1:0]             w_dabs;
    logic [MW:0]               w_try;
    logic [MW:0]               w_sub;
    logic                      w_ge;
    logic                      w_pos_big;
    logic                      w_neg_big;

    assign w_nabs = i_num[mta_pkg::NUM_W-1] ? mta_pkg::NUM_W'(-i_num) : i_num;
    assign w_dabs = i_den[MW-1] ? MW'(-i_den) : i_den;
    assign w_try  = {r_rem, r_dvd[DW-1]};
    assign w_ge   = (w_try >= {1'b0, r_den});
    assign w_sub  = w_try - {1'b0, r_den};

    // Quotient magnitude out of range for the sign.
    assign w_pos_big = |r_dvd[DW-1:31];
    assign w_neg_big = (|r_dvd[DW-1:32]) || (r_dvd[31] && (|r_dvd[30:0]));

    always_comb begin
        if (r_neg) begin
            o_quot = w_neg_big ? 32'sh80000000 : -$signed(r_dvd[31:0]);
        end else begin
            o_quot = w_pos_big ? 32'sh7fffffff : $signed(r_dvd[31:0]);
        end
    end

    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= {w_nabs[MW-1:0], FRAC_BITS'(0)};
            r_rem <= '0;
            r_den <= w_dabs;
            r_neg <= i_num[mta_pkg::NUM_W-1] ^ i_den[MW-1];
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sub[MW-1:0] : w_try[MW-1:0];
            r_dvd <= {r_dvd[DW-2:0], w_ge};
        end
    end

endmodule

// File: rtl/mta_back.sv
module mta_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  mta_pkg::t_cmd       i_cmd,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [1:0]          o_row_index,
    output logic signed [31:0]  o_col0,
    output logic signed [31:0]  o_col1,
    output logic signed [31:0]  o_col2,
    output logic signed [31:0]  o_col3,
    output logic                o_bad_range,
    output logic                o_last_row
);

    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
    localparam int AW = mta_pkg::ACC_W;

    typedef enum logic [2:0] {
        S_POP, S_DIV_GO, S_DIV_WAIT, S_ELEM, S_MUL, S_ACC, S_ROW_OUT
    } t_state;

    t_state r_state;
    mta_pkg::t_cmd r_cmd;
    logic signed [31:0] r_mat [16];
    logic signed [31:0] r_row_buf [4];
    logic signed [31:0] r_b00, r_b11, r_b22, r_b03, r_b13, r_b23;
    logic [2:0] r_div_idx;
    logic [1:0] r_row, r_col, r_k;
    logic signed [63:0] r_prod;
    logic signed [AW-1:0] r_acc;
    logic r_div_start;

    logic signed [mta_pkg::NUM_W-1:0]  w_num;
    logic signed [mta_pkg::DIFF_W-1:0] w_den;
    logic                              w_div_done;
    logic signed [31:0]                w_quot;
    logic [1:0]                        w_bk;
    logic signed [31:0]                w_b;
    logic signed [31:0]                w_m;
    logic signed [AW-1:0]              n_acc;
    logic signed [mta_pkg::NUM_W-1:0]  w_two;
    logic                              w_emit;

    assign w_two = mta_pkg::NUM_W'(ONE) <<< 1;

    always_comb begin
        case (r_div_idx)
            3'd0: begin w_num = w_two;                             w_den = r_cmd.rml; end
            3'd1: begin w_num = -mta_pkg::NUM_W'(r_cmd.rpl);       w_den = r_cmd.rml; end
            3'd2: begin w_num = w_two;                             w_den = r_cmd.tmb; end
            3'd3: begin w_num = -mta_pkg::NUM_W'(r_cmd.tpb);       w_den = r_cmd.tmb; end
            3'd4: begin w_num = -w_two;                            w_den = r_cmd.fmn; end
            default: begin w_num = -mta_pkg::NUM_W'(r_cmd.fpn);    w_den = r_cmd.fmn; end
        endcase
    end

    mta_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // Built matrix element at row w_bk, column r_col.
    assign w_bk = (r_state == S_MUL) ? r_k : r_row;

    always_comb begin
        if (w_bk == r_col) begin
            case (w_bk)
                2'd0:    w_b = r_b00;
                2'd1:    w_b = r_b11;
                2'd2:    w_b = r_b22;
                default: w_b = ONE;
            endcase
        end else if (r_col == 2'd3) begin
            case (w_bk)
                2'd0:    w_b = r_b03;
                2'd1:    w_b = r_b13;
                default: w_b = r_b23;
            endcase
        end else begin
            w_b = '0;
        end
    end

    assign w_m   = r_mat[{r_row, (r_state == S_MUL) ? r_k : r_col}];
    assign n_acc = r_acc + AW'(r_prod >>> FRAC_BITS);

    assign o_pop  = (r_state == S_POP) && !i_q_empty;
    assign w_emit = (r_state == S_ROW_OUT) && (!o_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_POP;
            r_div_start <= 1'b0;
            r_div_idx   <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_k         <= '0;
            o_valid     <= 1'b0;
            for (int i = 0; i < 16; i++) begin
                r_mat[i] <= (i[1:0] == i[3:2]) ? ONE : '0;
            end
        end else begin
            r_div_start <= 1'b0;
            if (w_emit) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_POP: begin
                    if (!i_q_empty) begin
                        r_cmd     <= i_cmd;
                        r_div_idx <= '0;
                        r_row     <= '0;
                        r_col     <= '0;
                        r_b00     <= ONE;
                        r_b11     <= ONE;
                        r_b22     <= ONE;
                        r_b03     <= i_cmd.tx;
                        r_b13     <= i_cmd.ty;
                        r_b23     <= i_cmd.tz;
                        if (i_cmd.translate || i_cmd.bad) begin
                            r_state <= S_ELEM;
                        end else begin
                            r_state <= S_DIV_GO;
                        end
                    end
                end
                S_DIV_GO: begin
                    r_div_start <= 1'b1;
                    r_state     <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (w_div_done) begin
                        case (r_div_idx)
                            3'd0:    r_b00 <= w_quot;
                            3'd1:    r_b03 <= w_quot;
                            3'd2:    r_b11 <= w_quot;
                            3'd3:    r_b13 <= w_quot;
                            3'd4:    r_b22 <= w_quot;
                            default: r_b23 <= w_quot;
                        endcase
                        r_div_idx <= r_div_idx + 1'b1;
                        r_state   <= (r_div_idx == 3'd5) ? S_ELEM : S_DIV_GO;
                    end
                end
                S_ELEM: begin
                    if (r_cmd.bad || r_cmd.load) begin
                        r_row_buf[r_col] <= r_cmd.bad ? w_m : w_b;
                        r_col   <= r_col + 1'b1;
                        r_state <= (r_col == 2'd3) ? S_ROW_OUT : S_ELEM;
                    end else begin
                        r_k     <= '0;
                        r_acc   <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= w_m * w_b;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc <= n_acc;
                    r_k   <= r_k + 1'b1;
                    if (r_k == 2'd3) begin
                        r_row_buf[r_col] <= mta_pkg::sat_acc(n_acc);
                        r_col   <= r_col + 1'b1;
                        r_state <= (r_col == 2'd3) ? S_ROW_OUT : S_ELEM;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_ROW_OUT: begin
                    if (w_emit) begin
                        for (int c = 0; c < 4; c++) begin
                            r_mat[{r_row, 2'(c)}] <= r_row_buf[c];
                        end
                        o_row_index <= r_row;
                        o_col0      <= r_row_buf[0];
                        o_col1      <= r_row_buf[1];
                        o_col2      <= r_row_buf[2];
                        o_col3      <= r_row_buf[3];
                        o_bad_range <= r_cmd.bad;
                        o_last_row  <= (r_row == 2'd3);
                        r_row       <= r_row + 1'b1;
                        r_col       <= '0;
                        r_state     <= (r_row == 2'd3) ? S_POP : S_ELEM;
                    end
                end
                default: r_state <= S_POP;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_row == (o_row_index == 2'd3)))
        else $error("last_row flag disagrees with row index");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROW_OUT && o_valid && !i_ready) |=> (r_state == S_ROW_OUT))
        else $error("row left while output register still full");

    a_div_only_ortho: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_start |-> (!r_cmd.translate && !r_cmd.bad))
        else $error("divider started for a command that needs none");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state != S_POP))
        else $error("pop did not start a command");
`endif

endmodule

// File: rtl/matrix_transform_accumulator_unit.sv
// Keeps a 4x4 Q16.16 transform matrix and applies one command per input item:
// an orthographic projection (mode 0) or a translation (mode 1), either loaded
// in place of the matrix or multiplied on its right (current = current * built).
// Input channel: i_valid / o_ready with mode, load and six arguments.
// Output channel: o_valid / i_ready; every item yields four results, rows 0..3
// in order, last_row set on row 3. bad_range marks a rejected ortho command,
// whose matrix is left unchanged and still emitted.
// Flow: a command passes a two-entry queue, then the back end pops it, runs six
// serial divisions (non-rejected ortho only), then builds 16 elements, each by a
// copy for a load or rejected command, or by a four-term multiply-accumulate on
// one shared 32x32 multiplier (Q16.16 by default), and emits a row after each
// four elements. One command is worked on at a time.
// Reset (synchronous, active low) sets the matrix to identity and empties the
// queue. A stalled receiver holds the output register; the back end waits at
// the next row, while the queue keeps taking items until full.
module matrix_transform_accumulator_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_mode,
    input  logic                i_load,
    input  logic signed [31:0]  i_arg_a,
    input  logic signed [31:0]  i_arg_b,
    input  logic signed [31:0]  i_arg_c,
    input  logic signed [31:0]  i_arg_d,
    input  logic signed [31:0]  i_arg_e,
    input  logic signed [31:0]  i_arg_f,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [1:0]          o_row_index,
    output logic signed [31:0]  o_col0,
    output logic signed [31:0]  o_col1,
    output logic signed [31:0]  o_col2,
    output logic signed [31:0]  o_col3,
    output logic                o_bad_range,
    output logic                o_last_row
);

    logic          w_push, w_pop, w_full, w_empty;
    mta_pkg::t_cmd w_in_cmd, w_q_cmd;

    mta_front u_front (
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_mode   (i_mode),
        .i_load   (i_load),
        .i_arg_a  (i_arg_a),
        .i_arg_b  (i_arg_b),
        .i_arg_c  (i_arg_c),
        .i_arg_d  (i_arg_d),
        .i_arg_e  (i_arg_e),
        .i_arg_f  (i_arg_f),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_cmd    (w_in_cmd)
    );

    mta_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_in_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_cmd   (w_q_cmd)
    );

    mta_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_empty),
        .i_cmd       (w_q_cmd),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_row_index (o_row_index),
        .o_col0      (o_col0),
        .o_col1      (o_col1),
        .o_col2      (o_col2),
        .o_col3      (o_col3),
        .o_bad_range (o_bad_range),
        .o_last_row  (o_last_row)
    );

endmodule

// File: tb/matrix_transform_accumulator_unit_tb.sv
module matrix_transform_accumulator_unit_tb;

    localparam int FRAC = 16;
    localparam longint ONE = 64'sd1 << FRAC;
    localparam int LIMIT_CYCLES = 900000;
    localparam int N_RANDOM = 390;
    localparam int N_DIRECTED = 20;

    typedef logic signed [31:0] t_q;

    typedef struct {
        logic       mode;
        logic       load;
        t_q         a, b, c, d, e, f;
        logic       typed;  // row carries hand-written diagonal result
        t_q         diag;
        logic       bad;
    } t_stim;

    typedef struct {
        logic [1:0] row;
        t_q         c0, c1, c2, c3;
        logic       bad;
        logic       last;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic       i_mode = 1'b0;
    logic       i_load = 1'b0;
    t_q         i_arg_a = '0, i_arg_b = '0, i_arg_c = '0;
    t_q         i_arg_d = '0, i_arg_e = '0, i_arg_f = '0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [1:0] o_row_index;
    t_q         o_col0, o_col1, o_col2, o_col3;
    logic       o_bad_range, o_last_row;

    matrix_transform_accumulator_unit dut (.*);

    always #4 i_clk = ~i_clk;

    t_q     xform [4][4];
    t_row   rows_due [$];
    int     errors = 0;
    longint cycles = 0;
    int     hold_off = 0;
    logic   feeding_done = 1'b0;
    t_stim  dir_tbl [N_DIRECTED];

    function automatic t_q clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return t_q'(v);
    endfunction

    // num << FRAC fits 50 bits, so 64-bit math is exact; division truncates to zero
    function automatic t_q qdiv(longint num, longint den);
        return clamp32((num * ONE) / den);
    endfunction

    function automatic longint floor_q(longint p);
        return p >>> FRAC;
    endfunction

    task automatic run_command(input t_stim s);
        t_q     built [4][4];
        t_q     nxt [4][4];
        longint acc, lo, hi, bo, to, ne, fa;
        logic   bad;
        bad = 1'b0;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                built[r][c] = (r == c) ? t_q'(ONE) : '0;
        lo = s.a; hi = s.b; bo = s.c; to = s.d; ne = s.e; fa = s.f;
        if (s.mode == mta_pkg::MODE_TRANSLATE) begin
            built[0][3] = s.a; built[1][3] = s.b; built[2][3] = s.c;
        end else if (s.a == s.b || s.c == s.d || s.e == s.f) begin
            bad = 1'b1;
        end else begin
            built[0][0] = qdiv(2 * ONE, hi - lo);
            built[1][1] = qdiv(2 * ONE, to - bo);
            built[2][2] = qdiv(-2 * ONE, fa - ne);
            built[0][3] = qdiv(-(hi + lo), hi - lo);
            built[1][3] = qdiv(-(to + bo), to - bo);
            built[2][3] = qdiv(-(fa + ne), fa - ne);
        end
        if (!bad) begin
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++) begin
                    if (s.load) begin
                        nxt[r][c] = built[r][c];
                    end else begin
                        acc = 0;
                        for (int k = 0; k < 4; k++)
                            acc += floor_q(longint'(xform[r][k]) * longint'(built[k][c]));
                        nxt[r][c] = clamp32(acc);
                    end
                end
            xform = nxt;
        end
        for (int r = 0; r < 4; r++) begin
            if (s.typed && (xform[r][r] !== s.diag || bad !== s.bad)) begin
                $display("%0t directed row %0d: expected diag %h bad %b, predicted %h bad %b",
                         $time, r, s.diag, s.bad, xform[r][r], bad);
                errors++;
            end
            rows_due.push_back('{row: 2'(r), c0: xform[r][0], c1: xform[r][1],
                                 c2: xform[r][2], c3: xform[r][3], bad: bad,
                                 last: (r == 3)});
        end
    endtask

    function automatic t_q rand_q(int kind);
        case (kind)
            0: return t_q'($urandom);
            1: return t_q'($urandom_range(0, 8 * ONE)) - t_q'(4 * ONE);
            2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return t_q'($urandom_range(0, 4)) <<< FRAC;
        endcase
    endfunction

    task automatic offer(input t_stim s);
        i_valid <= 1'b1;
        i_mode <= s.mode; i_load <= s.load;
        i_arg_a <= s.a; i_arg_b <= s.b; i_arg_c <= s.c;
        i_arg_d <= s.d; i_arg_e <= s.e; i_arg_f <= s.f;
        do @(posedge i_clk); while (!o_ready);
        run_command(s);
    endtask

    task automatic idle_for(int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    function automatic t_stim mk(logic m, logic l, t_q a, t_q b, t_q c, t_q d,
                                 t_q e, t_q f, logic typed, t_q diag, logic bad);
        t_stim s;
        s.mode = m; s.load = l; s.a = a; s.b = b; s.c = c; s.d = d; s.e = e;
        s.f = f; s.typed = typed; s.diag = diag; s.bad = bad;
        return s;
    endfunction

    initial begin
        t_stim s;
        int    burst, kind;
        t_q    one_q, mx, mn;
        logic  drained, held;
        one_q = t_q'(ONE); mx = 32'sh7fffffff; mn = 32'sh80000000;
        drained = 1'b0; held = 1'b0;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                xform[r][c] = (r == c) ? one_q : '0;
        // degenerate ortho right after reset shows identity
        dir_tbl[0]  = mk(mta_pkg::MODE_ORTHO, 1'b0, one_q, one_q, 0, one_q, 0, one_q,
                         1'b1, one_q, 1'b1);
        dir_tbl[1]  = mk(mta_pkg::MODE_ORTHO, 1'b1, 0, one_q, one_q, one_q, 0, one_q,
                         1'b1, one_q, 1'b1);
        dir_tbl[2]  = mk(mta_pkg::MODE_ORTHO, 1'b1, 0, one_q, 0, one_q, mx, mx,
                         1'b1, one_q, 1'b1);
        dir_tbl[3]  = mk(mta_pkg::MODE_TRANSLATE, 1'b1, mx, mn, mx, 0, 0, 0,
                         1'b1, one_q, 1'b0);
        dir_tbl[4]  = mk(mta_pkg::MODE_TRANSLATE, 1'b0, mx, mx, mn, mx, mn, mx,
                         1'b1, one_q, 1'b0);
        dir_tbl[5]  = mk(mta_pkg::MODE_TRANSLATE, 1'b0, -1, mn, -1, -1, -1, -1,
                         1'b0, 0, 1'b0);
        dir_tbl[6]  = mk(mta_pkg::MODE_ORTHO, 1'b1, -one_q, one_q, -one_q, one_q,
                         -one_q, one_q, 1'b0, 0, 1'b0);
        dir_tbl[7]  = mk(mta_pkg::MODE_ORTHO, 1'b0, 0, one_q, 0, one_q, 0, one_q,
                         1'b0, 0, 1'b0);
        dir_tbl[8]  = mk(mta_pkg::MODE_ORTHO, 1'b1, mn, mx, mn, mx, mn, mx, 1'b0, 0, 1'b0);
        dir_tbl[9]  = mk(mta_pkg::MODE_ORTHO, 1'b1, mx, mn, mx, mn, mx, mn, 1'b0, 0, 1'b0);
        // tiny ranges saturate the quotients
        dir_tbl[10] = mk(mta_pkg::MODE_ORTHO, 1'b1, 0, 1, 0, 1, 0, 1, 1'b0, 0, 1'b0);
        dir_tbl[11] = mk(mta_pkg::MODE_ORTHO, 1'b0, 0, -1, 0, -1, 0, -1, 1'b0, 0, 1'b0);
        dir_tbl[12] = mk(mta_pkg::MODE_TRANSLATE, 1'b0, 12345, -54321, 777, 0, 0, 0,
                         1'b0, 0, 1'b0);
        dir_tbl[13] = mk(mta_pkg::MODE_ORTHO, 1'b0, mn, mx, 5, 5, 1, 2, 1'b0, 0, 1'b1);
        dir_tbl[14] = mk(mta_pkg::MODE_ORTHO, 1'b0, -3 * one_q, 5 * one_q, 2 * one_q,
                         -one_q, one_q, 100 * one_q, 1'b0, 0, 1'b0);
        dir_tbl[15] = mk(mta_pkg::MODE_TRANSLATE, 1'b0, mn, mn, mn, 0, 0, 0, 1'b0, 0, 1'b0);
        dir_tbl[16] = mk(mta_pkg::MODE_ORTHO, 1'b0, 1, 3, -1, 7, 2, -2, 1'b0, 0, 1'b0);
        dir_tbl[17] = mk(mta_pkg::MODE_TRANSLATE, 1'b1, 0, 0, 0, 0, 0, 0,
                         1'b1, one_q, 1'b0);
        dir_tbl[18] = mk(mta_pkg::MODE_TRANSLATE, 1'b0, 32'h5555aaaa, 32'haaaa5555,
                         32'h0f0f0f0f, 0, 0, 0, 1'b0, 0, 1'b0);
        dir_tbl[19] = mk(mta_pkg::MODE_ORTHO, 1'b0, 32'h7ffeffff, -32'h7fff0000, 3,
                         32'h1_0003, -9, 32'h4000, 1'b0, 0, 1'b0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tbl[i]) begin
            offer(dir_tbl[i]);
            if ($urandom_range(0, 3) == 0) idle_for($urandom_range(1, 30));
        end
        i_valid <= 1'b0;

        for (int n = 0; n < N_RANDOM; ) begin
            // drain fully once, and hold the output off once
            if (!drained && n >= 60) begin
                drained = 1'b1;
                i_valid <= 1'b0;
                wait (rows_due.size() == 0);
                @(posedge i_clk);
            end
            if (!held && n >= 150) begin
                held = 1'b1;
                hold_off = 3000;
            end
            burst = $urandom_range(1, 12);
            for (int j = 0; j < burst && n < N_RANDOM; j++, n++) begin
                kind = $urandom_range(0, 3);
                s.mode = 1'($urandom_range(0, 1));
                s.load = ($urandom_range(0, 5) == 0);
                s.a = rand_q(kind); s.b = rand_q(kind); s.c = rand_q(kind);
                s.d = rand_q(kind); s.e = rand_q(kind); s.f = rand_q(kind);
                if ($urandom_range(0, 15) == 0) s.b = s.a;
                if ($urandom_range(0, 15) == 0) s.d = s.c;
                if ($urandom_range(0, 15) == 0) s.f = s.e;
                s.typed = 1'b0; s.diag = '0; s.bad = 1'b0;
                offer(s);
            end
            if ($urandom_range(0, 2) != 0) idle_for($urandom_range(1, 200));
        end
        i_valid <= 1'b0;
        feeding_done <= 1'b1;
    end

    // receiver: long hold-off when requested, otherwise its own stall pattern
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_ready <= 1'b0;
        end else if (cycles[9:8] == 2'b00) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge i_clk) begin
        t_row exp_row;
        if (i_rst_n && o_valid && i_ready) begin
            if (rows_due.size() == 0) begin
                $display("%0t unexpected row: row %0d", $time, o_row_index);
                errors++;
            end else begin
                exp_row = rows_due.pop_front();
                if (o_row_index !== exp_row.row || o_col0 !== exp_row.c0 ||
                    o_col1 !== exp_row.c1 || o_col2 !== exp_row.c2 ||
                    o_col3 !== exp_row.c3 || o_bad_range !== exp_row.bad ||
                    o_last_row !== exp_row.last) begin
                    $display("%0t mismatch: expected row %0d %h %h %h %h bad %b last %b",
                             $time, exp_row.row, exp_row.c0, exp_row.c1, exp_row.c2,
                             exp_row.c3, exp_row.bad, exp_row.last);
                    $display("%0t            actual row %0d %h %h %h %h bad %b last %b",
                             $time, o_row_index, o_col0, o_col1, o_col2, o_col3,
                             o_bad_range, o_last_row);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        wait (feeding_done);
        wait (rows_due.size() == 0);
        repeat (400) @(posedge i_clk);
        if (errors == 0 && rows_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: matrix_transform_accumulator_unit.f
rtl/mta_pkg.sv
rtl/mta_front.sv
rtl/mta_fifo.sv
rtl/mta_div.sv
rtl/mta_back.sv
rtl/matrix_transform_accumulator_unit.sv
tb/matrix_transform_accumulator_unit_tb.sv
